// ----- rtl/core/cvh_pkg.sv -----
// shared types and constants of the convex hull unit
`default_nettype none

package cvh_pkg;

  localparam int MaxPointsDef = 64;
  localparam int CoordBitsDef = 16;
  localparam int MinHull      = 3;

  // multiply-accumulate steps over d1 = a - o and d2 = b - o
  typedef enum logic [2:0] {
    MAC_NOP      = 3'd0,
    MAC_X1Y2_SET = 3'd1,
    MAC_Y1X2_SUB = 3'd2,
    MAC_X1X1_SET = 3'd3,
    MAC_Y1Y1_ADD = 3'd4,
    MAC_X2X2_SUB = 3'd5,
    MAC_Y2Y2_SUB = 3'd6
  } mac_op_e;

  typedef struct packed {
    logic    pt_we;
    logic    ord_we;
    logic    stk_we;
    logic    ld_anc;
    logic    o_from_anc;
    logic    ld_o;
    logic    ld_a;
    logic    ld_b;
    logic    ld_out;
    logic    out_last;
    logic    out_degen;
    logic    out_ovf;
    mac_op_e mac_op;
  } cvh_cmd_t;

  typedef struct packed {
    logic anc_lower;
    logic a_eq_o;
    logic b_eq_o;
    logic acc_zero;
    logic acc_neg;
  } cvh_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/convex_hull_graham_scan_unit.sv -----
// Convex hull by Graham scan. Points stream in one per cycle and are stored until an item with
// tlast; points past MAX_POINTS are dropped and flagged in tuser[1] of every vertex. The block
// then finds the lowest point, insertion-sorts the rest by angle through one shared
// multiply-accumulate unit (one comparison per shifted entry), prunes collinear runs, runs the
// stack scan (turn tests and pops) and emits the vertices from the top of the stack down to the
// anchor, each held until the output handshake; a set with fewer than MinHull points left after
// pruning yields a single zeroed vertex flagged degenerate. No new point is taken from the last
// point of a set until the final vertex of its hull has been taken.
`default_nettype none

module convex_hull_graham_scan_unit
  import cvh_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // point_x [15:0], point_y [31:16]
  input  wire logic        s_axis_tlast,   // last_point
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // hull_x [15:0], hull_y [31:16]
  output logic             m_axis_tlast,   // last_vertex
  output logic      [1:0]  m_axis_tuser    // degenerate [0], overflow [1]
);

  localparam int IW = $clog2(MAX_POINTS);

  cvh_cmd_t cmd;
  cvh_sts_t sts;
  logic [IW-1:0] pt_waddr, pt_raddr, ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic [IW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic [15:0] hull_x, hull_y;
  logic degen, ovf;

  cvh_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .pt_waddr_o  (pt_waddr),
    .pt_raddr_o  (pt_raddr),
    .ord_waddr_o (ord_waddr),
    .ord_wdata_o (ord_wdata),
    .ord_raddr_o (ord_raddr),
    .ord_rdata_i (ord_rdata),
    .stk_waddr_o (stk_waddr),
    .stk_wdata_o (stk_wdata),
    .stk_raddr_o (stk_raddr),
    .stk_rdata_i (stk_rdata)
  );

  cvh_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_x_i      (s_axis_tdata[15:0]),
    .in_y_i      (s_axis_tdata[31:16]),
    .pt_waddr_i  (pt_waddr),
    .pt_raddr_i  (pt_raddr),
    .ord_waddr_i (ord_waddr),
    .ord_wdata_i (ord_wdata),
    .ord_raddr_i (ord_raddr),
    .ord_rdata_o (ord_rdata),
    .stk_waddr_i (stk_waddr),
    .stk_wdata_i (stk_wdata),
    .stk_raddr_i (stk_raddr),
    .stk_rdata_o (stk_rdata),
    .hull_x_o    (hull_x),
    .hull_y_o    (hull_y),
    .last_o      (m_axis_tlast),
    .degen_o     (degen),
    .ovf_o       (ovf)
  );

  assign m_axis_tdata = {hull_y, hull_x};
  assign m_axis_tuser = {ovf, degen};

  // input and output sides are never open together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a vertex is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("degenerate result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after the last point");

endmodule

`default_nettype wire

// ----- rtl/core/cvh_datapath.sv -----
// point, order and stack memories, coordinate registers, MAC unit, output register
`default_nettype none

module cvh_datapath
  import cvh_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int COORD_BITS = CoordBitsDef,
  localparam int IW = $clog2(MAX_POINTS)
) (
  input  wire logic          clk_i,
  input  wire cvh_cmd_t      cmd_i,
  output cvh_sts_t           sts_o,
  input  wire logic [15:0]   in_x_i,
  input  wire logic [15:0]   in_y_i,
  input  wire logic [IW-1:0] pt_waddr_i,
  input  wire logic [IW-1:0] pt_raddr_i,
  input  wire logic [IW-1:0] ord_waddr_i,
  input  wire logic [IW-1:0] ord_wdata_i,
  input  wire logic [IW-1:0] ord_raddr_i,
  output logic      [IW-1:0] ord_rdata_o,
  input  wire logic [IW-1:0] stk_waddr_i,
  input  wire logic [IW-1:0] stk_wdata_i,
  input  wire logic [IW-1:0] stk_raddr_i,
  output logic      [IW-1:0] stk_rdata_o,
  output logic      [15:0]   hull_x_o,
  output logic      [15:0]   hull_y_o,
  output logic               last_o,
  output logic               degen_o,
  output logic               ovf_o
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int AW = 2 * DW + 2;

  logic [2*C-1:0] pt_mem [MAX_POINTS];
  logic [IW-1:0]  ord_mem [MAX_POINTS];
  logic [IW-1:0]  stk_mem [MAX_POINTS];
  logic [2*C-1:0] pt_rdata_q;

  logic [31:0] in_x_ext, in_y_ext;
  logic [C-1:0] rd_x, rd_y;
  logic [C-1:0] anc_x_q, anc_y_q, o_x_q, o_y_q, a_x_q, a_y_q, b_x_q, b_y_q;
  logic signed [DW-1:0] dx1, dy1, dx2, dy2, op1, op2;
  logic signed [2*DW-1:0] prod;
  logic signed [AW-1:0] prod_ext, acc_q, acc_d;
  logic [C-1:0] hx_q, hy_q;
  logic last_q, degen_q, ovf_q;
  logic [31:0] hx_ext, hy_ext;

  // coordinates keep their low bits, read back as signed
  assign in_x_ext = {16'b0, in_x_i};
  assign in_y_ext = {16'b0, in_y_i};
  assign rd_x = pt_rdata_q[C-1:0];
  assign rd_y = pt_rdata_q[2*C-1:C];

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_we) begin
      pt_mem[pt_waddr_i] <= {in_y_ext[C-1:0], in_x_ext[C-1:0]};
    end
    pt_rdata_q <= pt_mem[pt_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ord_we) begin
      ord_mem[ord_waddr_i] <= ord_wdata_i;
    end
    ord_rdata_o <= ord_mem[ord_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stk_we) begin
      stk_mem[stk_waddr_i] <= stk_wdata_i;
    end
    stk_rdata_o <= stk_mem[stk_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_anc) begin
      anc_x_q <= rd_x;
      anc_y_q <= rd_y;
    end
    if (cmd_i.o_from_anc) begin
      o_x_q <= anc_x_q;
      o_y_q <= anc_y_q;
    end else if (cmd_i.ld_o) begin
      o_x_q <= rd_x;
      o_y_q <= rd_y;
    end
    if (cmd_i.ld_a) begin
      a_x_q <= rd_x;
      a_y_q <= rd_y;
    end
    if (cmd_i.ld_b) begin
      b_x_q <= rd_x;
      b_y_q <= rd_y;
    end
  end

  assign dx1 = $signed({a_x_q[C-1], a_x_q}) - $signed({o_x_q[C-1], o_x_q});
  assign dy1 = $signed({a_y_q[C-1], a_y_q}) - $signed({o_y_q[C-1], o_y_q});
  assign dx2 = $signed({b_x_q[C-1], b_x_q}) - $signed({o_x_q[C-1], o_x_q});
  assign dy2 = $signed({b_y_q[C-1], b_y_q}) - $signed({o_y_q[C-1], o_y_q});

  always_comb begin
    unique case (cmd_i.mac_op)
      MAC_Y1X2_SUB: begin op1 = dy1; op2 = dx2; end
      MAC_X1X1_SET: begin op1 = dx1; op2 = dx1; end
      MAC_Y1Y1_ADD: begin op1 = dy1; op2 = dy1; end
      MAC_X2X2_SUB: begin op1 = dx2; op2 = dx2; end
      MAC_Y2Y2_SUB: begin op1 = dy2; op2 = dy2; end
      default:      begin op1 = dx1; op2 = dy2; end
    endcase
  end

  assign prod     = op1 * op2;
  assign prod_ext = AW'(prod);

  always_comb begin
    unique case (cmd_i.mac_op)
      MAC_X1Y2_SET, MAC_X1X1_SET:               acc_d = prod_ext;
      MAC_Y1Y1_ADD:                             acc_d = acc_q + prod_ext;
      MAC_Y1X2_SUB, MAC_X2X2_SUB, MAC_Y2Y2_SUB: acc_d = acc_q - prod_ext;
      default:                                  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign sts_o.anc_lower = ($signed(rd_y) < $signed(anc_y_q)) ||
                           ((rd_y == anc_y_q) && ($signed(rd_x) < $signed(anc_x_q)));
  assign sts_o.a_eq_o    = (a_x_q == o_x_q) && (a_y_q == o_y_q);
  assign sts_o.b_eq_o    = (b_x_q == o_x_q) && (b_y_q == o_y_q);
  assign sts_o.acc_zero  = (acc_q == '0);
  assign sts_o.acc_neg   = acc_q[AW-1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      hx_q    <= cmd_i.out_degen ? '0 : rd_x;
      hy_q    <= cmd_i.out_degen ? '0 : rd_y;
      last_q  <= cmd_i.out_last;
      degen_q <= cmd_i.out_degen;
      ovf_q   <= cmd_i.out_ovf;
    end
  end

  assign hx_ext   = {{(32-C){1'b0}}, hx_q};
  assign hy_ext   = {{(32-C){1'b0}}, hy_q};
  assign hull_x_o = hx_ext[15:0];
  assign hull_y_o = hy_ext[15:0];
  assign last_o   = last_q;
  assign degen_o  = degen_q;
  assign ovf_o    = ovf_q;

endmodule

`default_nettype wire

// ----- rtl/core/cvh_ctrl.sv -----
// sequencer of load, anchor search, insertion sort, collinear pruning, stack scan and emit
`default_nettype none

module cvh_ctrl
  import cvh_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDef,
  localparam int IW = $clog2(MAX_POINTS)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output cvh_cmd_t           cmd_o,
  input  wire cvh_sts_t      sts_i,
  output logic      [IW-1:0] pt_waddr_o,
  output logic      [IW-1:0] pt_raddr_o,
  output logic      [IW-1:0] ord_waddr_o,
  output logic      [IW-1:0] ord_wdata_o,
  output logic      [IW-1:0] ord_raddr_o,
  input  wire logic [IW-1:0] ord_rdata_i,
  output logic      [IW-1:0] stk_waddr_o,
  output logic      [IW-1:0] stk_wdata_o,
  output logic      [IW-1:0] stk_raddr_o,
  input  wire logic [IW-1:0] stk_rdata_i
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [42:0] {
    S_LOAD      = 43'd1 << 0,
    S_ANC_RD    = 43'd1 << 1,
    S_ANC_CMP   = 43'd1 << 2,
    S_SORT_INIT = 43'd1 << 3,
    S_SORT_NEXT = 43'd1 << 4,
    S_SORT_LDA  = 43'd1 << 5,
    S_SORT_CHK  = 43'd1 << 6,
    S_SORT_RDO  = 43'd1 << 7,
    S_SORT_LDB  = 43'd1 << 8,
    S_CMP_EQ    = 43'd1 << 9,
    S_CMP_C2    = 43'd1 << 10,
    S_CMP_CZ    = 43'd1 << 11,
    S_CMP_D2    = 43'd1 << 12,
    S_CMP_D3    = 43'd1 << 13,
    S_CMP_D4    = 43'd1 << 14,
    S_CMP_DR    = 43'd1 << 15,
    S_SORT_DEC  = 43'd1 << 16,
    S_RED_NEXT  = 43'd1 << 17,
    S_RED_RDK   = 43'd1 << 18,
    S_RED_LDA   = 43'd1 << 19,
    S_RED_RDK1  = 43'd1 << 20,
    S_RED_LDB   = 43'd1 << 21,
    S_RED_C1    = 43'd1 << 22,
    S_RED_C2    = 43'd1 << 23,
    S_RED_CZ    = 43'd1 << 24,
    S_RED_KEEP  = 43'd1 << 25,
    S_SCAN_INIT = 43'd1 << 26,
    S_SCAN_NEXT = 43'd1 << 27,
    S_SCAN_RDC  = 43'd1 << 28,
    S_SCAN_LDB  = 43'd1 << 29,
    S_SCAN_CHK  = 43'd1 << 30,
    S_SCAN_RDO  = 43'd1 << 31,
    S_SCAN_LDO  = 43'd1 << 32,
    S_SCAN_RDA  = 43'd1 << 33,
    S_SCAN_LDA  = 43'd1 << 34,
    S_SCAN_C1   = 43'd1 << 35,
    S_SCAN_C2   = 43'd1 << 36,
    S_SCAN_CZ   = 43'd1 << 37,
    S_DEGEN     = 43'd1 << 38,
    S_EMIT_NEXT = 43'd1 << 39,
    S_EMIT_RD   = 43'd1 << 40,
    S_EMIT_LD   = 43'd1 << 41,
    S_EMIT_WAIT = 43'd1 << 42
  } cvh_state_e;

  cvh_state_e state_q, state_d;
  logic [CW-1:0] n_q, n_d, i_q, i_d, j_q, j_d, m_q, m_d, k_q, k_d, w_q, w_d;
  logic [CW-1:0] depth_q, depth_d;
  logic [IW-1:0] anc_q, anc_d, jidx_q, jidx_d, kidx_q, kidx_d, cidx_q, cidx_d;
  logic before_q, before_d, ovf_q, ovf_d;
  logic [CW-1:0] i_inc, j_dec, k_inc, depth_inc, depth_m1, depth_m2, emit_pos;

  assign i_inc     = i_q + CW'(1);
  assign j_dec     = j_q - CW'(1);
  assign k_inc     = k_q + CW'(1);
  assign depth_inc = depth_q + CW'(1);
  assign depth_m1  = depth_q - CW'(1);
  assign depth_m2  = depth_q - CW'(2);
  assign emit_pos  = depth_m1 - k_q;

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = (state_q == S_EMIT_WAIT);

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    i_d      = i_q;
    j_d      = j_q;
    m_d      = m_q;
    k_d      = k_q;
    w_d      = w_q;
    depth_d  = depth_q;
    anc_d    = anc_q;
    jidx_d   = jidx_q;
    kidx_d   = kidx_q;
    cidx_d   = cidx_q;
    before_d = before_q;
    ovf_d    = ovf_q;
    cmd_o         = '0;
    cmd_o.mac_op  = MAC_NOP;
    cmd_o.out_ovf = ovf_q;
    pt_waddr_o  = n_q[IW-1:0];
    pt_raddr_o  = i_q[IW-1:0];
    ord_waddr_o = j_q[IW-1:0];
    ord_wdata_o = i_q[IW-1:0];
    ord_raddr_o = k_q[IW-1:0];
    stk_waddr_o = depth_q[IW-1:0];
    stk_wdata_o = cidx_q;
    stk_raddr_o = depth_m2[IW-1:0];

    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (n_q < CW'(MAX_POINTS)) begin
            cmd_o.pt_we = 1'b1;
            n_d = n_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            i_d = '0;
            state_d = S_ANC_RD;
          end
        end
      end
      S_ANC_RD: state_d = S_ANC_CMP;
      S_ANC_CMP: begin
        if (i_q == '0 || sts_i.anc_lower) begin
          anc_d = i_q[IW-1:0];
          cmd_o.ld_anc = 1'b1;
        end
        i_d = i_inc;
        state_d = (i_inc == n_q) ? S_SORT_INIT : S_ANC_RD;
      end
      S_SORT_INIT: begin
        cmd_o.ord_we = 1'b1;
        ord_waddr_o = '0;
        ord_wdata_o = anc_q;
        cmd_o.o_from_anc = 1'b1;
        m_d = CW'(1);
        i_d = '0;
        state_d = S_SORT_NEXT;
      end
      S_SORT_NEXT: begin
        if (i_q == n_q) begin
          k_d = CW'(1);
          w_d = CW'(1);
          state_d = S_RED_NEXT;
        end else if (i_q == CW'(anc_q)) begin
          i_d = i_inc;
        end else begin
          state_d = S_SORT_LDA;
        end
      end
      S_SORT_LDA: begin
        cmd_o.ld_a = 1'b1;
        j_d = m_q;
        state_d = S_SORT_CHK;
      end
      S_SORT_CHK: begin
        if (j_q > CW'(1)) begin
          ord_raddr_o = j_dec[IW-1:0];
          state_d = S_SORT_RDO;
        end else begin
          cmd_o.ord_we = 1'b1;
          m_d = m_q + CW'(1);
          i_d = i_inc;
          state_d = S_SORT_NEXT;
        end
      end
      S_SORT_RDO: begin
        jidx_d = ord_rdata_i;
        pt_raddr_o = ord_rdata_i;
        state_d = S_SORT_LDB;
      end
      S_SORT_LDB: begin
        cmd_o.ld_b = 1'b1;
        state_d = S_CMP_EQ;
      end
      // points equal to the anchor go first, then angle, then distance
      S_CMP_EQ: begin
        if (sts_i.a_eq_o != sts_i.b_eq_o) begin
          before_d = sts_i.a_eq_o;
          state_d = S_SORT_DEC;
        end else begin
          cmd_o.mac_op = MAC_X1Y2_SET;
          state_d = S_CMP_C2;
        end
      end
      S_CMP_C2: begin
        cmd_o.mac_op = MAC_Y1X2_SUB;
        state_d = S_CMP_CZ;
      end
      S_CMP_CZ: begin
        if (!sts_i.acc_zero) begin
          before_d = !sts_i.acc_neg;
          state_d = S_SORT_DEC;
        end else begin
          cmd_o.mac_op = MAC_X1X1_SET;
          state_d = S_CMP_D2;
        end
      end
      S_CMP_D2: begin
        cmd_o.mac_op = MAC_Y1Y1_ADD;
        state_d = S_CMP_D3;
      end
      S_CMP_D3: begin
        cmd_o.mac_op = MAC_X2X2_SUB;
        state_d = S_CMP_D4;
      end
      S_CMP_D4: begin
        cmd_o.mac_op = MAC_Y2Y2_SUB;
        state_d = S_CMP_DR;
      end
      S_CMP_DR: begin
        before_d = sts_i.acc_neg;
        state_d = S_SORT_DEC;
      end
      S_SORT_DEC: begin
        cmd_o.ord_we = 1'b1;
        if (before_q) begin
          ord_wdata_o = jidx_q;
          j_d = j_dec;
          state_d = S_SORT_CHK;
        end else begin
          m_d = m_q + CW'(1);
          i_d = i_inc;
          state_d = S_SORT_NEXT;
        end
      end
      S_RED_NEXT: begin
        if (k_q == m_q) begin
          m_d = w_q;
          state_d = S_SCAN_INIT;
        end else begin
          state_d = S_RED_RDK;
        end
      end
      S_RED_RDK: begin
        kidx_d = ord_rdata_i;
        pt_raddr_o = ord_rdata_i;
        state_d = S_RED_LDA;
      end
      S_RED_LDA: begin
        cmd_o.ld_a = 1'b1;
        if (k_inc < m_q) begin
          ord_raddr_o = k_inc[IW-1:0];
          state_d = S_RED_RDK1;
        end else begin
          state_d = S_RED_KEEP;
        end
      end
      S_RED_RDK1: begin
        pt_raddr_o = ord_rdata_i;
        state_d = S_RED_LDB;
      end
      S_RED_LDB: begin
        cmd_o.ld_b = 1'b1;
        state_d = S_RED_C1;
      end
      S_RED_C1: begin
        cmd_o.mac_op = MAC_X1Y2_SET;
        state_d = S_RED_C2;
      end
      S_RED_C2: begin
        cmd_o.mac_op = MAC_Y1X2_SUB;
        state_d = S_RED_CZ;
      end
      S_RED_CZ: begin
        if (sts_i.acc_zero) begin
          k_d = k_inc;
          state_d = S_RED_NEXT;
        end else begin
          state_d = S_RED_KEEP;
        end
      end
      S_RED_KEEP: begin
        cmd_o.ord_we = 1'b1;
        ord_waddr_o = w_q[IW-1:0];
        ord_wdata_o = kidx_q;
        w_d = w_q + CW'(1);
        k_d = k_inc;
        state_d = S_RED_NEXT;
      end
      S_SCAN_INIT: begin
        if (m_q < CW'(MinHull)) begin
          state_d = S_DEGEN;
        end else begin
          depth_d = '0;
          k_d = '0;
          state_d = S_SCAN_NEXT;
        end
      end
      S_SCAN_NEXT: begin
        if (k_q == m_q) begin
          k_d = '0;
          state_d = S_EMIT_NEXT;
        end else begin
          state_d = S_SCAN_RDC;
        end
      end
      S_SCAN_RDC: begin
        cidx_d = ord_rdata_i;
        pt_raddr_o = ord_rdata_i;
        state_d = S_SCAN_LDB;
      end
      S_SCAN_LDB: begin
        cmd_o.ld_b = 1'b1;
        state_d = S_SCAN_CHK;
      end
      // the first three points are pushed without a turn test
      S_SCAN_CHK: begin
        if (k_q >= CW'(MinHull) && depth_q >= CW'(2)) begin
          state_d = S_SCAN_RDO;
        end else begin
          cmd_o.stk_we = 1'b1;
          depth_d = depth_inc;
          k_d = k_inc;
          state_d = S_SCAN_NEXT;
        end
      end
      S_SCAN_RDO: begin
        pt_raddr_o = stk_rdata_i;
        state_d = S_SCAN_LDO;
      end
      S_SCAN_LDO: begin
        cmd_o.ld_o = 1'b1;
        stk_raddr_o = depth_m1[IW-1:0];
        state_d = S_SCAN_RDA;
      end
      S_SCAN_RDA: begin
        pt_raddr_o = stk_rdata_i;
        state_d = S_SCAN_LDA;
      end
      S_SCAN_LDA: begin
        cmd_o.ld_a = 1'b1;
        state_d = S_SCAN_C1;
      end
      S_SCAN_C1: begin
        cmd_o.mac_op = MAC_X1Y2_SET;
        state_d = S_SCAN_C2;
      end
      S_SCAN_C2: begin
        cmd_o.mac_op = MAC_Y1X2_SUB;
        state_d = S_SCAN_CZ;
      end
      S_SCAN_CZ: begin
        if (sts_i.acc_zero || sts_i.acc_neg) begin
          depth_d = depth_m1;
          state_d = S_SCAN_CHK;
        end else begin
          cmd_o.stk_we = 1'b1;
          depth_d = depth_inc;
          k_d = k_inc;
          state_d = S_SCAN_NEXT;
        end
      end
      S_DEGEN: begin
        cmd_o.ld_out = 1'b1;
        cmd_o.out_last = 1'b1;
        cmd_o.out_degen = 1'b1;
        depth_d = CW'(1);
        k_d = '0;
        state_d = S_EMIT_WAIT;
      end
      S_EMIT_NEXT: begin
        if (k_q == depth_q) begin
          n_d = '0;
          ovf_d = 1'b0;
          state_d = S_LOAD;
        end else begin
          stk_raddr_o = emit_pos[IW-1:0];
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        pt_raddr_o = stk_rdata_i;
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd_o.ld_out = 1'b1;
        cmd_o.out_last = (k_inc == depth_q);
        state_d = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_ready_i) begin
          k_d = k_inc;
          state_d = S_EMIT_NEXT;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      n_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      m_q      <= '0;
      k_q      <= '0;
      w_q      <= '0;
      depth_q  <= '0;
      anc_q    <= '0;
      jidx_q   <= '0;
      kidx_q   <= '0;
      cidx_q   <= '0;
      before_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      i_q      <= i_d;
      j_q      <= j_d;
      m_q      <= m_d;
      k_q      <= k_d;
      w_q      <= w_d;
      depth_q  <= depth_d;
      anc_q    <= anc_d;
      jidx_q   <= jidx_d;
      kidx_q   <= kidx_d;
      cidx_q   <= cidx_d;
      before_q <= before_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/convex_hull_graham_scan_unit_tb.sv -----
// testbench of the graham scan convex hull unit: directed and random point sets against a built-in predictor
`default_nettype none

module convex_hull_graham_scan_unit_tb
  import cvh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPts = MaxPointsDef;
  localparam int WatchLimit = 400000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } point_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic               degen;
    logic               ovf;
  } vertex_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  convex_hull_graham_scan_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  point_t  pending_points[$];
  vertex_t expected_vertices[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      hold_sender = 1'b0;
  int      quiet_cycles = 0;

  // hull predictor state
  longint set_x[NPts];
  longint set_y[NPts];
  int     set_count = 0;
  bit     set_ovf = 1'b0;

  function automatic longint cross_of(int o, int a, int b);
    return (set_x[a] - set_x[o]) * (set_y[b] - set_y[o]) -
           (set_y[a] - set_y[o]) * (set_x[b] - set_x[o]);
  endfunction

  function automatic bit angle_less(int o, int a, int b);
    bit     ao, bo;
    longint c, da, db;
    ao = (set_x[a] == set_x[o]) && (set_y[a] == set_y[o]);
    bo = (set_x[b] == set_x[o]) && (set_y[b] == set_y[o]);
    if (ao != bo) return ao;
    c = cross_of(o, a, b);
    if (c != 0) return c > 0;
    da = (set_x[a]-set_x[o])**2 + (set_y[a]-set_y[o])**2;
    db = (set_x[b]-set_x[o])**2 + (set_y[b]-set_y[o])**2;
    return da < db;
  endfunction

  task automatic predict_hull();
    int order[NPts];
    int stk[NPts];
    int anc, m, w, j, sp;
    vertex_t v;
    anc = 0;
    for (int i = 1; i < set_count; i++)
      if (set_y[i] < set_y[anc] || (set_y[i] == set_y[anc] && set_x[i] < set_x[anc])) anc = i;
    order[0] = anc;
    m = 1;
    for (int i = 0; i < set_count; i++) begin
      if (i == anc) continue;
      j = m;
      while (j > 1 && angle_less(anc, i, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
      m++;
    end
    // keep farthest of each run collinear with the anchor
    w = 1;
    for (int k = 1; k < m; k++) begin
      if (k + 1 < m && cross_of(anc, order[k], order[k+1]) == 0) continue;
      order[w++] = order[k];
    end
    m = w;
    if (m < MinHull) begin
      v = '{x: 0, y: 0, last: 1'b1, degen: 1'b1, ovf: set_ovf};
      expected_vertices.insert(expected_vertices.size(), v);
    end else begin
      sp = 0;
      for (int k = 0; k < m; k++) begin
        if (k >= MinHull)
          while (sp >= 2 && cross_of(stk[sp-2], stk[sp-1], order[k]) <= 0) sp--;
        stk[sp++] = order[k];
      end
      for (int k = 0; k < sp; k++) begin
        v.x = 16'(set_x[stk[sp-1-k]]);
        v.y = 16'(set_y[stk[sp-1-k]]);
        v.last = (k + 1 == sp);
        v.degen = 1'b0;
        v.ovf = set_ovf;
        expected_vertices.insert(expected_vertices.size(), v);
      end
    end
    set_count = 0;
    set_ovf = 1'b0;
  endtask

  task automatic take_point(point_t p);
    if (set_count < NPts) begin
      set_x[set_count] = p.x;
      set_y[set_count] = p.y;
      set_count++;
    end else begin
      set_ovf = 1'b1;
    end
    if (p.last) predict_hull();
  endtask

  task automatic report_mismatch(string what, vertex_t got, vertex_t exp_v);
    $display("mismatch %s: got x=%0d y=%0d l=%0b d=%0b o=%0b, want x=%0d y=%0d l=%0b d=%0b o=%0b",
             what, got.x, got.y, got.last, got.degen, got.ovf,
             exp_v.x, exp_v.y, exp_v.last, exp_v.degen, exp_v.ovf);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_points.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          point_t p;
          p = pending_points.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {p.y, p.x};
          s_axis_tlast  <= p.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    vertex_t got, exp_v;
    point_t  p;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        p.x = s_axis_tdata[15:0];
        p.y = s_axis_tdata[31:16];
        p.last = s_axis_tlast;
        take_point(p);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got = '{x: m_axis_tdata[15:0], y: m_axis_tdata[31:16], last: m_axis_tlast,
                degen: m_axis_tuser[0], ovf: m_axis_tuser[1]};
        if (expected_vertices.size() == 0) begin
          report_mismatch("unexpected", got, '0);
        end else begin
          exp_v = expected_vertices.pop_front();
          if (got !== exp_v) report_mismatch("field", got, exp_v);
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (!moved && quiet_cycles + 1 >= WatchLimit) begin
        $display("FAIL convex_hull_graham_scan_unit");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_coord(int spread);
    case ($urandom_range(5))
      0: return 16'(16'h8000 + $urandom_range(3));
      1: return 16'(16'h7fff - $urandom_range(3));
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(2 * spread)) - spread);
    endcase
  endfunction

  task automatic queue_set(int n, int spread);
    point_t p;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(5) == 0) begin
        p = pending_points[$];  // repeat a point
        p.last = 1'b0;
      end else begin
        p.x = rand_coord(spread);
        p.y = rand_coord(spread);
      end
      if ($urandom_range(7) == 0) begin
        // point on the line y = 2x through the origin
        p.x = 16'($urandom_range(8));
        p.y = 16'(p.x * 2);
      end
      p.last = (i == n - 1);
      pending_points.insert(pending_points.size(), p);
    end
  endtask

  task automatic queue_xy(int x, int y, bit last);
    point_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.last = last;
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || s_axis_tvalid || expected_vertices.size() > 0) begin
      @(posedge clk_i);
      if (quiet_cycles > WatchLimit) begin
        $display("FAIL convex_hull_graham_scan_unit");
        $finish;
      end
    end
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int phase_pct[4][2] = '{'{0, 0}, '{65, 0}, '{0, 65}, '{9, 9}};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: single point, pair, collinear, square with interior and duplicates, corners
    queue_xy(5, 5, 1'b1);
    queue_xy(-32768, -32768, 1'b0); queue_xy(32767, 32767, 1'b1);
    queue_xy(0, 0, 1'b0); queue_xy(1, 1, 1'b0); queue_xy(2, 2, 1'b1);
    queue_xy(0, 0, 1'b0); queue_xy(0, 0, 1'b0); queue_xy(10, 0, 1'b0); queue_xy(10, 10, 1'b0);
    queue_xy(5, 5, 1'b0); queue_xy(0, 10, 1'b0); queue_xy(5, 0, 1'b0); queue_xy(0, 5, 1'b1);
    queue_xy(-32768, 32767, 1'b0); queue_xy(32767, -32768, 1'b0); queue_xy(-32768, -32768, 1'b0);
    queue_xy(32767, 32767, 1'b1);
    wait_drained();
    // overflow: 67 points in one set
    queue_set(67, 1000);
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_pct[ph][0];
      recv_stall_pct = phase_pct[ph][1];
      for (int s = 0; s < 10; s++)
        queue_set($urandom_range(1, 14), ($urandom_range(1) != 0) ? 20 : 30000);
      if (ph == 1) begin
        // sender waits for every vertex of the earlier sets
        while (pending_points.size() > 0) @(posedge clk_i);
        hold_sender = 1'b1;
        while (expected_vertices.size() > 0 && quiet_cycles <= WatchLimit) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("PASS convex_hull_graham_scan_unit");
    end else begin
      $display("FAIL convex_hull_graham_scan_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/cvh_pkg.sv
rtl/core/cvh_datapath.sv
rtl/core/cvh_ctrl.sv
rtl/core/convex_hull_graham_scan_unit.sv
tb/sv/convex_hull_graham_scan_unit_tb.sv
